FILE: design/ibc_pkg.sv
// Shared widths, types and state codes of the incremental bounding circle.
`timescale 1ns / 1ps
package ibc_pkg;

  localparam int CoordWidth = 32;
  localparam int CoefBits   = 32;
  localparam int RadWidth   = CoordWidth - 1;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int SqWidth    = 2 * DiffWidth;
  localparam int RootWidth  = DiffWidth;
  localparam int SumWidth   = RootWidth + 1;
  localparam int DenWidth   = RootWidth + 1;
  localparam int RemWidth   = RootWidth + 5;
  localparam int OffWidth   = SqWidth - CoefBits;
  localparam int NewWidth   = OffWidth + 2;
  localparam int StepWidth  = $clog2(RootWidth + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQR, S_CMP, S_ROOT, S_DLOAD, S_DIV, S_OFFX, S_OFFY,
    S_OFFW, S_FIN
  } ibc_state_e;

  // Command to the shared root / divide unit
  typedef struct packed {
    logic load;
    logic step;
    logic is_div;
  } ibc_cmd_t;

endpackage

FILE: design/ibc_mul.sv
// Shared registered unsigned multiplier.
`timescale 1ns / 1ps
module ibc_mul (
  input  logic                            clk_i,
  input  logic [ibc_pkg::DiffWidth-1:0]   a_i,
  input  logic [ibc_pkg::DiffWidth-1:0]   b_i,
  output logic [ibc_pkg::SqWidth-1:0]     p_o
);
  import ibc_pkg::*;

  logic [SqWidth-1:0] p_q;

  // One product per cycle, registered
  always_ff @(posedge clk_i) begin
    p_q <= SqWidth'(a_i) * SqWidth'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: design/ibc_sqdiv.sv
// Shift-subtract unit, one digit per cycle while stepped: integer square root or division.
`timescale 1ns / 1ps
module ibc_sqdiv (
  input  logic                           clk_i,
  input  ibc_pkg::ibc_cmd_t              cmd_i,
  input  logic [ibc_pkg::SqWidth-1:0]    src_i,
  input  logic [ibc_pkg::RemWidth-1:0]   rem_i,
  input  logic [ibc_pkg::DenWidth-1:0]   den_i,
  output logic [ibc_pkg::RootWidth-1:0]  q_o
);
  import ibc_pkg::*;

  logic [SqWidth-1:0]   src_q, src_d;
  logic [RemWidth-1:0]  rem_q, rem_d;
  logic [RootWidth-1:0] q_q, q_d;
  logic [DenWidth-1:0]  den_q, den_d;
  logic [RemWidth-1:0]  cand, trial;
  logic                 take;

  // Candidate remainder and trial value for this digit
  always_comb begin
    if (cmd_i.is_div) begin
      cand  = {rem_q[RemWidth-2:0], src_q[SqWidth-1]};
      trial = RemWidth'(den_q);
    end else begin
      cand  = {rem_q[RemWidth-3:0], src_q[SqWidth-1:SqWidth-2]};
      trial = {(RemWidth-2)'(q_q), 2'b01};
    end
    take = cand >= trial;
  end

  always_comb begin
    src_d = src_q;
    rem_d = rem_q;
    q_d   = q_q;
    den_d = den_q;
    if (cmd_i.load) begin
      src_d = src_i;
      rem_d = rem_i;
      q_d   = '0;
      den_d = den_i;
    end else if (cmd_i.step) begin
      src_d = cmd_i.is_div ? {src_q[SqWidth-2:0], 1'b0} : {src_q[SqWidth-3:0], 2'b00};
      rem_d = take ? cand - trial : cand;
      q_d   = {q_q[RootWidth-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

  assign q_o = q_q;

endmodule

FILE: design/ibc_ctrl.sv
// Sequencer and circle state of the incremental bounding circle.
`timescale 1ns / 1ps
module ibc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_fire_i,
  input  logic signed [ibc_pkg::CoordWidth-1:0] px_i,
  input  logic signed [ibc_pkg::CoordWidth-1:0] py_i,
  input  logic                              start_i,
  input  logic                              out_stall_i,
  output logic                              busy_o,
  output logic                              out_valid_o,
  output logic signed [ibc_pkg::CoordWidth-1:0] cx_o,
  output logic signed [ibc_pkg::CoordWidth-1:0] cy_o,
  output logic [ibc_pkg::RadWidth-1:0]      r_o,
  output logic                              grew_o
);
  import ibc_pkg::*;

  localparam logic signed [NewWidth-1:0] CMax = NewWidth'((64'sd1 <<< (CoordWidth-1)) - 1);
  localparam logic signed [NewWidth-1:0] CMin = -CMax - NewWidth'(1);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(RootWidth - 1);

  ibc_state_e state_q, state_d;
  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic signed [CoordWidth-1:0] cx_q, cx_d, cy_q, cy_d, px_q, py_q;
  logic [RadWidth-1:0] r_q, r_d;
  logic grew_q, grew_d, ov_q, ov_d;
  logic [DiffWidth-1:0] ax_q, ay_q;
  logic sgx_q, sgy_q;
  logic [SqWidth-1:0] s_q, s_d;
  logic [RootWidth-1:0] d_q, d_d, k_q, k_d;
  logic signed [NewWidth-1:0] nx_q, nx_d;
  logic [DiffWidth-1:0] ma, mb;
  logic [SqWidth-1:0] prod;
  ibc_cmd_t cmd;
  logic [SqWidth-1:0] ud_src;
  logic [RemWidth-1:0] ud_rem;
  logic [RootWidth-1:0] ud_q;
  logic [SumWidth-1:0] sum;
  logic signed [DiffWidth-1:0] dx, dy;
  logic signed [NewWidth-1:0] newc;
  logic signed [CoordWidth-1:0] satc, satx;
  logic [RadWidth-1:0] nr;

  ibc_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(prod));

  ibc_sqdiv u_sqdiv (
    .clk_i(clk_i), .cmd_i(cmd), .src_i(ud_src), .rem_i(ud_rem),
    .den_i({d_q, 1'b0}), .q_o(ud_q)
  );

  assign dx  = DiffWidth'(cx_q) - DiffWidth'(px_i);
  assign dy  = DiffWidth'(cy_q) - DiffWidth'(py_i);
  assign sum = SumWidth'(d_q) + SumWidth'(r_q);

  // Signed offset from the product of the last cycle, saturated; new radius
  always_comb begin
    logic [OffWidth-1:0] off;
    logic signed [NewWidth-1:0] base;
    logic sg;
    off  = prod[SqWidth-1:CoefBits];
    sg   = (state_q == S_FIN) ? sgy_q : sgx_q;
    base = (state_q == S_FIN) ? NewWidth'(py_q) : NewWidth'(px_q);
    newc = sg ? base - NewWidth'(off) : base + NewWidth'(off);
    if (newc > CMax)      satc = CMax[CoordWidth-1:0];
    else if (newc < CMin) satc = CMin[CoordWidth-1:0];
    else                  satc = newc[CoordWidth-1:0];
    if (nx_q > CMax)      satx = CMax[CoordWidth-1:0];
    else if (nx_q < CMin) satx = CMin[CoordWidth-1:0];
    else                  satx = nx_q[CoordWidth-1:0];
    nr = (sum[SumWidth-1:1] > SumWidth'({RadWidth{1'b1}})) ? {RadWidth{1'b1}}
                                                           : sum[RadWidth:1];
  end

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    r_d     = r_q;
    grew_d  = grew_q;
    ov_d    = ov_q && out_stall_i;
    s_d     = s_q;
    d_d     = d_q;
    k_d     = k_q;
    nx_d    = nx_q;
    ma      = ax_q;
    mb      = ax_q;
    cmd     = '0;
    ud_src  = s_q;
    ud_rem  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          if (start_i) begin
            cx_d    = px_i;
            cy_d    = py_i;
            r_d     = '0;
            grew_d  = (px_i != cx_q) || (py_i != cy_q) || (r_q != '0);
            ov_d    = 1'b1;
          end else begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        ma = ay_q;
        mb = ay_q;
        s_d = prod;
        state_d = S_SQR;
      end
      S_SQR: begin
        ma = DiffWidth'(r_q);
        mb = DiffWidth'(r_q);
        s_d = s_q + prod;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd.load = 1'b1;
        cnt_d    = '0;
        if (prod > s_q || s_q == '0) begin
          state_d = S_FIN;
          nx_d    = NewWidth'(cx_q);
          grew_d  = 1'b0;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastStep) state_d = S_DLOAD;
      end
      S_DLOAD: begin
        d_d        = ud_q;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd.is_div = 1'b1;
        if (cnt_q == '0 && d_q != '0 && !cmd.step) begin
          cmd.load = 1'b1;
        end
        ud_src = {sum[0], {(SqWidth-1){1'b0}}};
        ud_rem = RemWidth'(sum[SumWidth-1:1]);
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q != '0) cmd.step = 1'b1;
        if (cnt_q == StepWidth'(RootWidth)) state_d = S_OFFX;
      end
      S_OFFX: begin
        k_d     = ud_q;
        state_d = S_OFFY;
      end
      S_OFFY: begin
        ma = ax_q;
        mb = k_q;
        state_d = S_OFFW;
      end
      S_OFFW: begin
        nx_d    = newc;
        ma      = ay_q;
        mb      = k_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        // Keep the Y product steady while the write waits
        ma = ay_q;
        mb = k_q;
        if (!(ov_q && out_stall_i)) begin
          if (grew_q) begin
            cx_d   = satx;
            cy_d   = satc;
            r_d    = nr;
            grew_d = (satx != cx_q) || (satc != cy_q) || (nr != r_q);
          end
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // FIN via the offset path marks growth in grew_q before the final write
    if (state_q == S_OFFX) grew_d = 1'b1;
  end

  // X offset, held until the final write
  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
  end

  // Control and circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      r_q     <= '0;
      grew_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      r_q     <= r_d;
      grew_q  <= grew_d;
      ov_q    <= ov_d;
    end
  end

  // Item payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      px_q  <= px_i;
      py_q  <= py_i;
      sgx_q <= dx[DiffWidth-1];
      sgy_q <= dy[DiffWidth-1];
      ax_q  <= dx[DiffWidth-1] ? DiffWidth'(-dx) : DiffWidth'(dx);
      ay_q  <= dy[DiffWidth-1] ? DiffWidth'(-dy) : DiffWidth'(dy);
    end
    s_q <= s_d;
    d_q <= d_d;
    k_q <= k_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign cx_o        = cx_q;
  assign cy_o        = cy_q;
  assign r_o         = r_q;
  assign grew_o      = grew_q;

endmodule

FILE: design/incremental_bounding_circle_top.sv
// Top level of the incremental bounding circle.
// A start-of-set point updates the circle straight from idle; a point inside the
// circle, or on a zero-radius circle's centre, takes only the squares and compare;
// a growing point also takes the 33-step square root and 33-step division in the unit.
// Throughput: one item at a time; the input stalls while an item is in work.
// Reset (rst_ni low, asynchronous): circle at the origin with radius zero.
`timescale 1ns / 1ps
module incremental_bounding_circle_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  point_valid_i,
  output logic                                  point_stall_o,
  input  logic signed [ibc_pkg::CoordWidth-1:0] point_x_i,
  input  logic signed [ibc_pkg::CoordWidth-1:0] point_y_i,
  input  logic                                  start_new_set_i,
  output logic                                  result_valid_o,
  input  logic                                  result_stall_i,
  output logic signed [ibc_pkg::CoordWidth-1:0] center_x_o,
  output logic signed [ibc_pkg::CoordWidth-1:0] center_y_o,
  output logic [ibc_pkg::RadWidth-1:0]          radius_o,
  output logic                                  grew_o
);
  import ibc_pkg::*;

  logic busy;

  // Stall while an item is in work, or a start result cannot yet be shown
  assign point_stall_o = busy || (result_valid_o && result_stall_i);

  ibc_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_fire_i(point_valid_i && !point_stall_o),
    .px_i(point_x_i), .py_i(point_y_i), .start_i(start_new_set_i),
    .out_stall_i(result_stall_i), .busy_o(busy), .out_valid_o(result_valid_o),
    .cx_o(center_x_o), .cy_o(center_y_o), .r_o(radius_o), .grew_o(grew_o)
  );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the incremental bounding circle.
`timescale 1ns / 1ps
module testbench;
  import ibc_pkg::*;

  localparam int  WatchdogLimit = 4000;
  localparam int  DrainCycles   = 120;
  localparam longint CoordMax   = 64'sd2147483647;
  localparam longint CoordMin   = -64'sd2147483648;
  localparam longint RadMax     = 64'sd2147483647;

  typedef struct {
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic [RadWidth-1:0]          rad;
    logic                         grew;
  } circle_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         point_valid_i = 1'b0;
  logic                         point_stall_o;
  logic signed [CoordWidth-1:0] point_x_i = '0;
  logic signed [CoordWidth-1:0] point_y_i = '0;
  logic                         start_new_set_i = 1'b0;
  logic                         result_valid_o;
  logic                         result_stall_i = 1'b0;
  logic signed [CoordWidth-1:0] center_x_o;
  logic signed [CoordWidth-1:0] center_y_o;
  logic [RadWidth-1:0]          radius_o;
  logic                         grew_o;

  // Predictor state
  longint  model_cx, model_cy, model_r;
  circle_t expected_circles[$];

  int  error_count, points_sent, results_seen, growths_seen;
  bit  idling_on = 1'b1;
  int  quiet_cycles = 0;

  incremental_bounding_circle_top u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Bit-exact circle update for one point
  function automatic circle_t update_circle(input longint px, input longint py,
                                            input bit first);
    circle_t     res;
    longint      nx, ny, nr, dx, dy;
    logic [127:0] ax, ay, s, rr, root, t, d, sum, k, off;
    nx = model_cx; ny = model_cy; nr = model_r;
    if (first) begin
      nx = px; ny = py; nr = 0;
    end else begin
      dx = model_cx - px;
      dy = model_cy - py;
      ax = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay = (dy < 0) ? 128'(-dy) : 128'(dy);
      s  = ax * ax + ay * ay;
      rr = 128'(model_r) * 128'(model_r);
      if (!(s < rr)) begin
        root = '0;
        for (int i = 40; i >= 0; i--) begin
          t = root | (128'd1 << i);
          if (t * t <= s) root = t;
        end
        d = root;
        if (d != 0) begin
          sum = d + 128'(model_r);
          k   = (sum << CoefBits) / (d << 1);
          off = (ax * k) >> CoefBits;
          nx  = px + ((dx < 0) ? -longint'(off) : longint'(off));
          off = (ay * k) >> CoefBits;
          ny  = py + ((dy < 0) ? -longint'(off) : longint'(off));
          nx  = (nx > CoordMax) ? CoordMax : (nx < CoordMin) ? CoordMin : nx;
          ny  = (ny > CoordMax) ? CoordMax : (ny < CoordMin) ? CoordMin : ny;
          nr  = longint'(sum >> 1);
          if (nr > RadMax) nr = RadMax;
        end
      end
    end
    res.grew = (nx != model_cx) || (ny != model_cy) || (nr != model_r);
    model_cx = nx; model_cy = ny; model_r = nr;
    res.cx = nx[CoordWidth-1:0];
    res.cy = ny[CoordWidth-1:0];
    res.rad = nr[RadWidth-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Send one point; valid stays high unless an idle burst follows
  task automatic send_point(input logic signed [CoordWidth-1:0] px,
                            input logic signed [CoordWidth-1:0] py, input bit first);
    int gap;
    point_valid_i   <= 1'b1;
    point_x_i       <= px;
    point_y_i       <= py;
    start_new_set_i <= first;
    @(posedge clk_i);
    while (point_stall_o) @(posedge clk_i);
    expected_circles.push_back(update_circle(px, py, first));
    points_sent++;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      point_valid_i   <= 1'b0;
      point_x_i       <= $urandom;
      point_y_i       <= $urandom;
      start_new_set_i <= 1'($urandom_range(0, 1));
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected result has come
  task automatic wait_for_results;
    point_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_circles.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CoordWidth-1:0] near(input logic signed [CoordWidth-1:0] base);
    int sh;
    longint v;
    sh = $urandom_range(0, 31);
    v  = longint'(base) + (longint'($signed($urandom)) >>> sh);
    v  = (v > CoordMax) ? CoordMax : (v < CoordMin) ? CoordMin : v;
    return v[CoordWidth-1:0];
  endfunction

  // Extremes, flag, inside, on-circle, coincident and saturation cases
  task automatic test_directed;
    send_point(0, 0, 1'b0);                       // coincident with reset circle
    send_point(32'sh0001_0000, 0, 1'b0);          // grows from reset circle
    send_point(0, 0, 1'b0);                       // on the circle edge
    send_point(32'sh0000_8000, 0, 1'b0);          // strictly inside
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1); // same circle again
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0); // full diagonal
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0); // coincident, zero radius
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'shffff_ffff, 32'sh0000_0001, 1'b1);
    send_point(32'sh0000_0001, 32'shffff_ffff, 1'b0);
    send_point(32'sh0000_0003, 32'sh0000_0000, 1'b0);
    send_point(32'sh5555_5555, 32'shaaaa_aaaa, 1'b0);
    wait_for_results();
  endtask

  // Well-formed sets: a flagged first point then neighbours at mixed spreads
  task automatic test_random_sets(input int n_points);
    logic signed [CoordWidth-1:0] base_x, base_y;
    int left;
    left = n_points;
    while (left > 0) begin
      base_x = $urandom;
      base_y = $urandom;
      send_point(base_x, base_y, 1'b1);
      left--;
      repeat ($urandom_range(1, 12)) begin
        send_point(near(base_x), near(base_y), 1'b0);
        left--;
      end
    end
  endtask

  // Unstructured points with random flags
  task automatic test_random_noise(input int n_points);
    repeat (n_points) send_point($urandom, $urandom, ($urandom_range(0, 7) == 0));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    circle_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      results_seen++;
      if (expected_circles.size() == 0) begin
        error_count++;
        $display("MISMATCH result %0d arrived with nothing expected", results_seen);
      end else begin
        want = expected_circles.pop_front();
        if (grew_o) growths_seen++;
        if (center_x_o !== want.cx) report_mismatch("center_x", center_x_o, want.cx);
        if (center_y_o !== want.cy) report_mismatch("center_y", center_y_o, want.cy);
        if (radius_o !== want.rad) report_mismatch("radius", radius_o, want.rad);
        if (grew_o !== want.grew) report_mismatch("grew", grew_o, want.grew);
      end
    end
  end

  // Receiver stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      result_stall_i <= 1'b1;
    end else begin
      result_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((point_valid_i && !point_stall_o) || (result_valid_o && !result_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results outstanding", expected_circles.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    model_cx = 0; model_cy = 0; model_r = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sets(300);
    wait_for_results();
    test_random_noise(150);
    idling_on = 1'b0;
    test_random_sets(150);
    point_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_circles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d points and %0d results, %0d of which changed the circle",
             points_sent, results_seen, growths_seen);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: incremental_bounding_circle_top.f
design/ibc_pkg.sv
design/ibc_mul.sv
design/ibc_sqdiv.sv
design/ibc_ctrl.sv
design/incremental_bounding_circle_top.sv
verif/testbench.sv
